[design/sptw_pkg.sv]
// Shared constants, register codes and a helper function for the scan point
// to world transform. No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package sptw_pkg;

  localparam int RANGE_W    = 16;
  localparam int ANG_W      = 16;
  localparam int POSE_W     = 24;
  localparam int OUT_W      = 25;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int TRIG_W     = 33;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_POSE_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POSE_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POSE_Z    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROLL      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_YAW       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE = 3'd7;

  localparam logic signed [33:0] ONE_Q30      = 34'sd1073741824;
  localparam logic signed [35:0] ONE_Q30_W    = 36'sd1073741824;
  localparam logic signed [33:0] PI_Q30       = 34'sd3373259426;
  localparam logic signed [33:0] HALF_PI_Q30  = 34'sd1686629713;
  localparam logic signed [33:0] NHALF_PI_Q30 = -34'sd1686629713;

  localparam logic signed [25:0] OUT_MAX = 26'sd16777215;
  localparam logic signed [25:0] OUT_MIN = -26'sd16777216;

  // Series divisors and their reciprocals scaled by 2^34 (rounded down).
  localparam int RECIP_SHIFT = 34;
  localparam logic [7:0] SIN_DIV [0:5] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
  localparam logic [7:0] COS_DIV [0:5] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
  localparam logic [34:0] SIN_RECIP [0:5] = '{35'd110127366, 35'd156180628, 35'd238609294,
                                              35'd409044504, 35'd858993459, 35'd2863311530};
  localparam logic [34:0] COS_RECIP [0:5] = '{35'd130150524, 35'd190887435, 35'd306783378,
                                              35'd572662306, 35'd1431655765, 35'd8589934592};

  // Pipeline depth of the sine/cosine unit.
  localparam int TRIG_LAT = 22;

  // Division by 2^30 with truncation toward zero.
  function automatic logic signed [37:0] trunc_q30(input logic signed [67:0] v);
    logic signed [67:0] b;
    begin
      b = v[67] ? v + 68'sd1073741823 : v;
      trunc_q30 = b[67:30];
    end
  endfunction

endpackage

[design/sptw_trig.sv]
// Pipelined sine and cosine of a Q3.13 angle, results in Q30.
// Horner-form series, one term per three stages. Depends on sptw_pkg.
`timescale 1ns / 1ps

module sptw_trig (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [sptw_pkg::ANG_W-1:0]   angle,
  output logic signed [sptw_pkg::TRIG_W-1:0]  sin_q30,
  output logic signed [sptw_pkg::TRIG_W-1:0]  cos_q30
);

  typedef struct packed {
    logic [31:0]        x2;
    logic signed [31:0] x;
    logic               neg;
  } trig_carry_t;

  logic signed [33:0] x_raw;
  logic signed [33:0] x_fold;
  logic               neg_next;

  logic signed [31:0] a_x;
  logic               a_neg;
  logic signed [63:0] b_p;
  logic signed [31:0] b_x;
  logic               b_neg;

  trig_carry_t        c1 [6];
  trig_carry_t        c2 [6];
  trig_carry_t        c3 [6];
  logic signed [66:0] m1 [6][2];
  logic [32:0]        a2 [6][2];
  logic [67:0]        p2 [6][2];
  logic               g2 [6][2];
  logic signed [33:0] t3 [6][2];

  logic signed [65:0] f_ms;
  logic signed [33:0] f_c;
  logic               f_neg;
  logic signed [37:0] f_s;

  assign x_raw = {angle[sptw_pkg::ANG_W-1], angle, 17'd0};

  // Fold the angle into [-pi/2, pi/2]; the sign of both results flips.
  always_comb begin
    x_fold   = x_raw;
    neg_next = 1'b0;
    if (x_raw > sptw_pkg::HALF_PI_Q30) begin
      x_fold   = x_raw - sptw_pkg::PI_Q30;
      neg_next = 1'b1;
    end else if (x_raw < sptw_pkg::NHALF_PI_Q30) begin
      x_fold   = x_raw + sptw_pkg::PI_Q30;
      neg_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_x   <= x_fold[31:0];
      a_neg <= neg_next;
      b_p   <= a_x * a_x;
      b_x   <= a_x;
      b_neg <= a_neg;
    end
  end

  genvar i, l;
  generate
    for (i = 0; i < 6; i++) begin : g_step
      trig_carry_t cin;
      if (i == 0) begin : g_first
        assign cin = '{x2: b_p[61:30], x: b_x, neg: b_neg};
      end else begin : g_next
        assign cin = c3[i-1];
      end

      always_ff @(posedge clk) begin
        if (en) begin
          c1[i] <= cin;
          c2[i] <= c1[i];
          c3[i] <= c2[i];
        end
      end

      for (l = 0; l < 2; l++) begin : g_lane
        localparam logic [7:0]  DIV = (l == 0) ? sptw_pkg::SIN_DIV[i] : sptw_pkg::COS_DIV[i];
        localparam logic [34:0] RCP = (l == 0) ? sptw_pkg::SIN_RECIP[i]
                                               : sptw_pkg::COS_RECIP[i];
        logic signed [33:0] tin;
        logic signed [37:0] q;
        logic [37:0]        qabs;
        logic [33:0]        q0;
        logic [41:0]        rem;
        logic [33:0]        qc;
        logic signed [35:0] tn;

        if (i == 0) begin : g_seed
          assign tin = sptw_pkg::ONE_Q30;
        end else begin : g_chain
          assign tin = t3[i-1][l];
        end

        // The reciprocal estimate is low by at most one; one compare fixes it.
        always_comb begin
          q    = sptw_pkg::trunc_q30({m1[i][l][66], m1[i][l]});
          qabs = q[37] ? -q : q;
          q0   = p2[i][l][67:sptw_pkg::RECIP_SHIFT];
          rem  = {9'd0, a2[i][l]} - ({8'd0, q0} * {34'd0, DIV});
          qc   = q0 + {33'd0, (rem >= {34'd0, DIV})};
          tn   = g2[i][l] ? sptw_pkg::ONE_Q30_W + $signed({2'b00, qc})
                          : sptw_pkg::ONE_Q30_W - $signed({2'b00, qc});
        end

        always_ff @(posedge clk) begin
          if (en) begin
            m1[i][l] <= $signed({1'b0, cin.x2}) * tin;
            a2[i][l] <= qabs[32:0];
            p2[i][l] <= qabs[32:0] * RCP;
            g2[i][l] <= q[37];
            t3[i][l] <= tn[33:0];
          end
        end
      end
    end
  endgenerate

  assign f_s = sptw_pkg::trunc_q30({{2{f_ms[65]}}, f_ms});

  always_ff @(posedge clk) begin
    if (en) begin
      f_ms    <= c3[5].x * t3[5][0];
      f_c     <= t3[5][1];
      f_neg   <= c3[5].neg;
      sin_q30 <= f_neg ? -f_s[32:0] : f_s[32:0];
      cos_q30 <= f_neg ? -f_c[32:0] : f_c[32:0];
    end
  end

endmodule

[design/scan_point_to_world_transform.sv]
// Throughput: one beam per cycle; the whole pipeline freezes while a finished
// point is stalled, so a stalled output stalls the input in the same cycle.
// Beams outside the range window travel as bubbles and give no point.
// Reset clears the valid bits and sets the configuration registers to their defaults.
`timescale 1ns / 1ps

module scan_point_to_world_transform (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   beam_valid,
  output logic                                   beam_stall,
  input  logic [sptw_pkg::RANGE_W-1:0]           range_mm,
  input  logic signed [sptw_pkg::ANG_W-1:0]      beam_angle,
  output logic                                   point_valid,
  input  logic                                   point_stall,
  output logic signed [sptw_pkg::OUT_W-1:0]      point_x,
  output logic signed [sptw_pkg::OUT_W-1:0]      point_y,
  output logic signed [sptw_pkg::OUT_W-1:0]      point_z,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [sptw_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [sptw_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int D = sptw_pkg::TRIG_LAT;

  logic signed [sptw_pkg::POSE_W-1:0] pose_x_mm, pose_y_mm, pose_z_mm;
  logic signed [sptw_pkg::ANG_W-1:0]  roll_angle, pitch_angle, yaw_angle;
  logic [sptw_pkg::RANGE_W-1:0]       min_range_mm, max_range_mm;

  logic en;
  logic keep;

  logic [sptw_pkg::RANGE_W-1:0] rng_dly [D];
  logic                         vld_dly [D];
  logic                         vld_p   [1:8];

  logic signed [sptw_pkg::TRIG_W-1:0] sb, cb, sy, cy, sr, cr, sp, cp;

  logic signed [49:0] px1, py1;
  logic signed [33:0] x2, y2;
  logic signed [65:0] pa3, pb3, pc3, pd3;
  logic signed [33:0] x4, y4;
  logic signed [66:0] pe5, pf5;
  logic signed [33:0] y5;
  logic signed [33:0] x6, y6, z6;
  logic signed [66:0] pg7, ph7, pi7, pj7;
  logic signed [33:0] x7;
  logic signed [33:0] x8, y8, z8;

  logic signed [49:0] px1_adj, py1_adj;
  logic signed [37:0] q_nx, q_ny, q_x6, q_z6, q_y8, q_z8;

  assign cfg_ready  = 1'b1;
  assign en         = !point_valid || !point_stall;
  assign beam_stall = !en;
  assign keep       = (range_mm >= min_range_mm) && (range_mm <= max_range_mm);

  always_ff @(posedge clk) begin
    if (rst) begin
      pose_x_mm    <= '0;
      pose_y_mm    <= '0;
      pose_z_mm    <= '0;
      roll_angle   <= '0;
      pitch_angle  <= '0;
      yaw_angle    <= '0;
      min_range_mm <= '0;
      max_range_mm <= '1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sptw_pkg::REG_POSE_X:    pose_x_mm    <= cfg_data;
        sptw_pkg::REG_POSE_Y:    pose_y_mm    <= cfg_data;
        sptw_pkg::REG_POSE_Z:    pose_z_mm    <= cfg_data;
        sptw_pkg::REG_ROLL:      roll_angle   <= cfg_data[15:0];
        sptw_pkg::REG_PITCH:     pitch_angle  <= cfg_data[15:0];
        sptw_pkg::REG_YAW:       yaw_angle    <= cfg_data[15:0];
        sptw_pkg::REG_MIN_RANGE: min_range_mm <= cfg_data[15:0];
        sptw_pkg::REG_MAX_RANGE: max_range_mm <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // The pose angles run through their own units alongside the beam, so a
  // freshly written angle is ready when the first beam after it needs it.
  sptw_trig u_trig_beam  (.clk(clk), .en(en), .angle(beam_angle),  .sin_q30(sb), .cos_q30(cb));
  sptw_trig u_trig_yaw   (.clk(clk), .en(en), .angle(yaw_angle),   .sin_q30(sy), .cos_q30(cy));
  sptw_trig u_trig_roll  (.clk(clk), .en(en), .angle(roll_angle),  .sin_q30(sr), .cos_q30(cr));
  sptw_trig u_trig_pitch (.clk(clk), .en(en), .angle(pitch_angle), .sin_q30(sp), .cos_q30(cp));

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < D; k++) vld_dly[k] <= 1'b0;
      for (int k = 1; k <= 8; k++) vld_p[k] <= 1'b0;
      point_valid <= 1'b0;
    end else if (en) begin
      vld_dly[0] <= beam_valid && keep;
      for (int k = 1; k < D; k++) vld_dly[k] <= vld_dly[k-1];
      vld_p[1] <= vld_dly[D-1];
      for (int k = 2; k <= 8; k++) vld_p[k] <= vld_p[k-1];
      point_valid <= vld_p[8];
    end
  end

  always_comb begin
    px1_adj = px1[49] ? px1 + 50'sd65535 : px1;
    py1_adj = py1[49] ? py1 + 50'sd65535 : py1;
    q_nx = sptw_pkg::trunc_q30({{2{pa3[65]}}, pa3} - {{2{pb3[65]}}, pb3});
    q_ny = sptw_pkg::trunc_q30({{2{pc3[65]}}, pc3} + {{2{pd3[65]}}, pd3});
    q_x6 = sptw_pkg::trunc_q30({pe5[66], pe5});
    q_z6 = sptw_pkg::trunc_q30({pf5[66], pf5});
    q_y8 = sptw_pkg::trunc_q30({pg7[66], pg7} - {ph7[66], ph7});
    q_z8 = sptw_pkg::trunc_q30({pi7[66], pi7} + {pj7[66], pj7});
  end

  // Q14 millimetres to millimetres (ties away from zero), pose, saturation.
  function automatic logic signed [24:0] finish_mm(input logic signed [33:0] v,
                                                   input logic signed [23:0] pose);
    logic [33:0]        av;
    logic [33:0]        rnd;
    logic signed [25:0] mm;
    logic signed [25:0] sum;
    begin
      av  = v[33] ? -v : v;
      rnd = av + 34'd8192;
      mm  = v[33] ? -$signed({6'd0, rnd[33:14]}) : $signed({6'd0, rnd[33:14]});
      sum = mm + {{2{pose[23]}}, pose};
      if (sum > sptw_pkg::OUT_MAX) sum = sptw_pkg::OUT_MAX;
      if (sum < sptw_pkg::OUT_MIN) sum = sptw_pkg::OUT_MIN;
      finish_mm = sum[24:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      rng_dly[0] <= range_mm;
      for (int k = 1; k < D; k++) rng_dly[k] <= rng_dly[k-1];
      // Polar to Cartesian in Q14 mm.
      px1 <= $signed({1'b0, rng_dly[D-1]}) * cb;
      py1 <= $signed({1'b0, rng_dly[D-1]}) * sb;
      x2  <= px1_adj[49:16];
      y2  <= py1_adj[49:16];
      // Yaw about z.
      pa3 <= cy * x2;
      pb3 <= sy * y2;
      pc3 <= sy * x2;
      pd3 <= cy * y2;
      x4  <= q_nx[33:0];
      y4  <= q_ny[33:0];
      // Roll about y; the sensor point starts with z at zero.
      pe5 <= cr * x4;
      pf5 <= sr * x4;
      y5  <= y4;
      x6  <= q_x6[33:0];
      z6  <= -q_z6[33:0];
      y6  <= y5;
      // Pitch about x.
      pg7 <= cp * y6;
      ph7 <= sp * z6;
      pi7 <= sp * y6;
      pj7 <= cp * z6;
      x7  <= x6;
      x8  <= x7;
      y8  <= q_y8[33:0];
      z8  <= q_z8[33:0];
      point_x <= finish_mm(x8, pose_x_mm);
      point_y <= finish_mm(y8, pose_y_mm);
      point_z <= finish_mm(z8, pose_z_mm);
    end
  end

  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (rst)
    beam_stall |-> (point_valid && point_stall))
    else $error("input stalled while the output register was free");

  a_reset_clears_output: assert property (@(posedge clk)
    $past(rst) |-> !point_valid)
    else $error("point valid after reset");

  a_reject_short_range: assert property (@(posedge clk) disable iff (rst)
    (beam_valid && !beam_stall && (range_mm < min_range_mm)) |=> !vld_dly[0])
    else $error("beam below the minimum range entered the pipeline");

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for scan_point_to_world_transform: predicts each
// world point from beam requests and pose registers. Depends on sptw_pkg.
`timescale 1ns / 1ps

module tb_top;

  localparam int LATENCY   = 30;
  localparam int WDOG_MAX  = 20000;
  localparam longint Q30   = 64'sd1073741824;
  localparam longint PI30  = 64'sd3373259426;
  localparam longint HPI30 = 64'sd1686629713;

  typedef struct {
    logic signed [sptw_pkg::OUT_W-1:0] x;
    logic signed [sptw_pkg::OUT_W-1:0] y;
    logic signed [sptw_pkg::OUT_W-1:0] z;
  } world_point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic beam_valid = 1'b0;
  logic beam_stall;
  logic [sptw_pkg::RANGE_W-1:0] range_mm = '0;
  logic signed [sptw_pkg::ANG_W-1:0] beam_angle = '0;
  logic point_valid;
  logic point_stall = 1'b0;
  logic signed [sptw_pkg::OUT_W-1:0] point_x, point_y, point_z;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [sptw_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [sptw_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow copy of the register file.
  logic signed [23:0] pose_x, pose_y, pose_z;
  logic signed [15:0] roll_a, pitch_a, yaw_a;
  logic [15:0] min_r, max_r;

  world_point_t expected_points[$];
  int send_idle_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int quiet_cycles = 0;

  scan_point_to_world_transform dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void sin_cos(input logic signed [15:0] ang, output longint s,
                                  output longint c);
    longint sin_d[6] = '{156, 110, 72, 42, 20, 6};
    longint cos_d[6] = '{132, 90, 56, 30, 12, 2};
    longint x, x2, ts, tc;
    bit flip;
    x = longint'(ang) * 131072;
    flip = 1'b0;
    if (x > HPI30) begin
      x -= PI30;
      flip = 1'b1;
    end else if (x < -HPI30) begin
      x += PI30;
      flip = 1'b1;
    end
    x2 = (x * x) / Q30;
    ts = Q30;
    tc = Q30;
    for (int i = 0; i < 6; i++) begin
      ts = Q30 - ((x2 * ts) / Q30) / sin_d[i];
      tc = Q30 - ((x2 * tc) / Q30) / cos_d[i];
    end
    ts = (x * ts) / Q30;
    s = flip ? -ts : ts;
    c = flip ? -tc : tc;
  endfunction

  function automatic logic signed [sptw_pkg::OUT_W-1:0] q14_to_world(input longint v,
                                                          input logic signed [23:0] p);
    longint r;
    r = (v >= 0) ? (v + 8192) / 16384 : -((-v + 8192) / 16384);
    r += longint'(p);
    if (r > 16777215) r = 16777215;
    if (r < -16777216) r = -16777216;
    return r[sptw_pkg::OUT_W-1:0];
  endfunction

  task automatic predict_world_point(input logic [15:0] rng, input logic signed [15:0] ang);
    longint r, sb, cb, s, c, x, y, z, nx, ny, nz;
    world_point_t wp;
    r = longint'(rng);
    if (rng < min_r || rng > max_r) return;
    sin_cos(ang, sb, cb);
    x = (r * cb) / 65536;
    y = (r * sb) / 65536;
    z = 0;
    sin_cos(yaw_a, s, c);
    nx = (c * x - s * y) / Q30;
    ny = (s * x + c * y) / Q30;
    x = nx;
    y = ny;
    sin_cos(roll_a, s, c);
    nx = (c * x + s * z) / Q30;
    nz = (c * z - s * x) / Q30;
    x = nx;
    z = nz;
    sin_cos(pitch_a, s, c);
    ny = (c * y - s * z) / Q30;
    nz = (s * y + c * z) / Q30;
    wp.x = q14_to_world(x, pose_x);
    wp.y = q14_to_world(ny, pose_y);
    wp.z = q14_to_world(nz, pose_z);
    expected_points = {expected_points, wp};
  endtask

  // Stall driver and result checker share the sampling edge.
  always @(posedge clk) begin
    world_point_t wp;
    if (!rst && point_valid && !point_stall) begin
      if (expected_points.size() == 0) begin
        $error("unexpected point %0d %0d %0d", point_x, point_y, point_z);
        errors++;
      end else begin
        wp = expected_points.pop_front();
        if (point_x !== wp.x) begin
          $error("point_x expected %0d actual %0d", wp.x, point_x);
          errors++;
        end
        if (point_y !== wp.y) begin
          $error("point_y expected %0d actual %0d", wp.y, point_y);
          errors++;
        end
        if (point_z !== wp.z) begin
          $error("point_z expected %0d actual %0d", wp.z, point_z);
          errors++;
        end
      end
    end
    point_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (beam_valid && !beam_stall) || (point_valid && !point_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_MAX) begin
      $display("scan_point_to_world_transform: mismatch");
      $finish;
    end
  end

  // The request stays up after acceptance; the next idle cycle, drain or
  // pause drops it, so back-to-back requests see a single assignment per edge.
  task automatic send_beam(input logic [15:0] rng, input logic signed [15:0] ang);
    while ($urandom_range(99) < send_idle_pct) begin
      beam_valid <= 1'b0;
      @(posedge clk);
    end
    beam_valid <= 1'b1;
    range_mm <= rng;
    beam_angle <= ang;
    @(posedge clk);
    while (beam_stall) @(posedge clk);
    predict_world_point(rng, ang);
  endtask

  task automatic drain();
    beam_valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    // Rejected beams may still be in flight as bubbles.
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [sptw_pkg::CFG_IDX_W-1:0] idx,
                           input logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      sptw_pkg::REG_POSE_X:    pose_x = val;
      sptw_pkg::REG_POSE_Y:    pose_y = val;
      sptw_pkg::REG_POSE_Z:    pose_z = val;
      sptw_pkg::REG_ROLL:      roll_a = val[15:0];
      sptw_pkg::REG_PITCH:     pitch_a = val[15:0];
      sptw_pkg::REG_YAW:       yaw_a = val[15:0];
      sptw_pkg::REG_MIN_RANGE: min_r = val[15:0];
      sptw_pkg::REG_MAX_RANGE: max_r = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_pose(input logic [23:0] px, py, pz, input logic [15:0] ro, pi, ya,
                          input logic [15:0] lo, hi);
    drain();
    write_reg(sptw_pkg::REG_POSE_X, px);
    write_reg(sptw_pkg::REG_POSE_Y, py);
    write_reg(sptw_pkg::REG_POSE_Z, pz);
    write_reg(sptw_pkg::REG_ROLL, {8'd0, ro});
    write_reg(sptw_pkg::REG_PITCH, {8'd0, pi});
    write_reg(sptw_pkg::REG_YAW, {8'd0, ya});
    write_reg(sptw_pkg::REG_MIN_RANGE, {8'd0, lo});
    write_reg(sptw_pkg::REG_MAX_RANGE, {8'd0, hi});
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [15:0] rand_angle();
    if ($urandom_range(9) == 0) return 16'($urandom());
    return $signed(16'($urandom_range(51472))) - 16'sd25736;
  endfunction

  task automatic test_directed_extremes();
    logic [15:0] rngs[6] = '{16'd0, 16'd1, 16'd65535, 16'd32768, 16'd1000, 16'd65534};
    logic signed [15:0] angs[6] = '{16'sd0, 16'sd25736, -16'sd25736, 16'sh7fff,
                                    16'sh8000, 16'sd12868};
    for (int i = 0; i < 6; i++)
      for (int j = 0; j < 3; j++) send_beam(rngs[i], angs[(i + j) % 6]);
  endtask

  task automatic test_range_window();
    // Bounds are inclusive; then a minimum above the maximum rejects everything.
    set_pose(24'd100, -24'sd100, 24'd5, 16'd0, 16'd0, 16'd0, 16'd500, 16'd600);
    send_beam(16'd499, 16'sd0);
    send_beam(16'd500, 16'sd0);
    send_beam(16'd600, 16'sd3000);
    send_beam(16'd601, 16'sd0);
    set_pose(24'd0, 24'd0, 24'd0, 16'd0, 16'd0, 16'd0, 16'd700, 16'd600);
    send_beam(16'd650, 16'sd0);
    send_beam(16'd700, 16'sd0);
    // Unknown register indexes do not exist with a 3-bit index; all eight are used.
  endtask

  task automatic test_saturation();
    set_pose(24'h7fffff, 24'h800000, 24'h7fffff, 16'sh7fff, 16'sh8000, 16'sd25736,
             16'd0, 16'd65535);
    for (int i = 0; i < 6; i++) send_beam(16'd65535, rand_angle());
  endtask

  task automatic random_phase(input int n, input int idle, input int stl);
    send_idle_pct = idle;
    stall_pct = stl;
    set_pose(24'($urandom()), 24'($urandom()), 24'($urandom()), rand_angle(), rand_angle(),
             rand_angle(), 16'($urandom_range(2000)), 16'(65535 - $urandom_range(3000)));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(4) == 0) send_beam(16'($urandom()), rand_angle());
      else send_beam(16'($urandom_range(60000) + 2000), rand_angle());
      if (i == n / 2 && idle != 0) begin
        // Pause the sender until the pipeline is empty.
        beam_valid <= 1'b0;
        while (expected_points.size() != 0) @(posedge clk);
      end
    end
  endtask

  task automatic test_random();
    random_phase(170, 0, 0);
    random_phase(160, 60, 0);
    random_phase(160, 0, 60);
    random_phase(160, 15, 15);
  endtask

  initial begin
    pose_x = 0; pose_y = 0; pose_z = 0;
    roll_a = 0; pitch_a = 0; yaw_a = 0;
    min_r = 16'd0; max_r = 16'd65535;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_extremes();
    test_range_window();
    test_saturation();
    test_random();
    send_idle_pct = 0;
    stall_pct = 0;
    drain();
    if (errors == 0)
      $display("scan_point_to_world_transform: match");
    else
      $display("scan_point_to_world_transform: mismatch");
    $finish;
  end
endmodule
